FILE: rtl/core/ppurs_pkg.sv
// ============================================================================
// ppurs_pkg
// Shared types and constants of the picture-unit register and scroll block.
// ============================================================================
package ppurs_pkg;

    localparam int PAL_DEPTH   = 32;
    localparam int PAL_IDX_W   = $clog2(PAL_DEPTH);
    localparam int PAL_DATA_W  = 6;

    typedef enum logic [3:0] {
        OP_REG_WRITE  = 4'd0,
        OP_REG_READ   = 4'd1,
        OP_MEM_RETURN = 4'd2,
        OP_SET_FLAG   = 4'd3,
        OP_LINE_START = 4'd4,
        OP_LINE_END   = 4'd5,
        OP_RELOAD     = 4'd6,
        OP_SOFT_RESET = 4'd7,
        OP_HARD_RESET = 4'd8
    } op_t;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2
    } req_t;

    typedef struct packed {
        logic                  clear;
        logic                  wr_en;
        logic                  rd_en;
        logic [PAL_IDX_W-1:0]  index;
        logic [PAL_DATA_W-1:0] wdata;
    } pal_cmd_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        pal_read;
        req_t        mem_request;
        logic [13:0] mem_address;
        logic [7:0]  mem_write_data;
        logic        nmi_pulse;
        logic        nmi_enable;
        logic        render_on;
        logic [14:0] scroll_address;
        logic [2:0]  fine_x;
    } result_t;

endpackage

FILE: rtl/core/ppu_register_scroll_unit.sv
// ============================================================================
// ppu_register_scroll_unit
// CPU-facing registers and scroll counters of a picture unit, with a
// 32-entry palette held in a synchronous memory.
//
//   Channel   Prefix  Direction  Carries
//   input     s_      in         one register access or event per beat
//   result    m_      out        one result beat per input beat
//
// Each beat is decoded and the state updated in the cycle it is accepted;
// the result appears in the next cycle, with a palette read taken straight
// from the memory's registered output. With m_ready held high a beat is
// taken every cycle. A stalled result holds, and a new beat is taken in the
// same cycle that the waiting result is taken. Reset clears all state and
// the palette valid bits at once; no clearing pass is needed.
// ============================================================================
module ppu_register_scroll_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_operation,
    input  logic [2:0]  s_reg_index,
    input  logic [7:0]  s_bus_data,
    input  logic [7:0]  s_mem_data,
    input  logic [1:0]  s_flag_select,
    input  logic        s_flag_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_read_data,
    output logic [1:0]  m_mem_request,
    output logic [13:0] m_mem_address,
    output logic [7:0]  m_mem_write_data,
    output logic        m_nmi_pulse,
    output logic        m_nmi_enable,
    output logic        m_render_on,
    output logic [14:0] m_scroll_address,
    output logic [2:0]  m_fine_x_out
);
    import ppurs_pkg::*;

    logic                  accept;
    result_t               result;
    pal_cmd_t              pal_cmd;
    logic [PAL_DATA_W-1:0] pal_data;
    result_t               out_reg;
    logic                  out_valid_reg;

    assign s_ready = !out_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    ppurs_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .operation   (s_operation),
        .reg_index   (s_reg_index),
        .bus_data    (s_bus_data),
        .mem_data    (s_mem_data),
        .flag_select (s_flag_select),
        .flag_value  (s_flag_value),
        .result      (result),
        .pal_cmd     (pal_cmd)
    );

    ppurs_pal_mem u_pal_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (pal_cmd),
        .rd_data (pal_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s_ready) begin
            out_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_read_data      = out_reg.pal_read ? {{(8-PAL_DATA_W){1'b0}}, pal_data}
                                               : out_reg.read_data;
    assign m_mem_request    = out_reg.mem_request;
    assign m_mem_address    = out_reg.mem_address;
    assign m_mem_write_data = out_reg.mem_write_data;
    assign m_nmi_pulse      = out_reg.nmi_pulse;
    assign m_nmi_enable     = out_reg.nmi_enable;
    assign m_render_on      = out_reg.render_on;
    assign m_scroll_address = out_reg.scroll_address;
    assign m_fine_x_out     = out_reg.fine_x;

endmodule

FILE: rtl/core/ppurs_pal_mem.sv
// ============================================================================
// ppurs_pal_mem
// Palette memory with registered read data and per-entry valid bits that a
// reset or a clear command drops, so unwritten entries read as zero.
// ============================================================================
module ppurs_pal_mem (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  ppurs_pkg::pal_cmd_t             cmd,
    output logic [ppurs_pkg::PAL_DATA_W-1:0] rd_data
);
    import ppurs_pkg::*;

    logic [PAL_DATA_W-1:0] mem [PAL_DEPTH];
    logic [PAL_DEPTH-1:0]  valid_reg;
    logic [PAL_DATA_W-1:0] q_reg;
    logic                  q_valid_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.index] <= cmd.wdata;
        end
        if (cmd.rd_en) begin
            q_reg <= mem[cmd.index];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clear) begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            if (cmd.wr_en) begin
                valid_reg[cmd.index] <= 1'b1;
            end
            if (cmd.rd_en) begin
                q_valid_reg <= valid_reg[cmd.index];
            end
        end
    end

    assign rd_data = q_valid_reg ? q_reg : '0;

endmodule

FILE: rtl/core/ppurs_ctrl.sv
// ============================================================================
// ppurs_ctrl
// Register state and event decode: control, mask, status, scroll addresses,
// fine X, write toggle, read buffer and bus latch, plus palette commands.
// ============================================================================
module ppurs_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [3:0]           operation,
    input  logic [2:0]           reg_index,
    input  logic [7:0]           bus_data,
    input  logic [7:0]           mem_data,
    input  logic [1:0]           flag_select,
    input  logic                 flag_value,
    output ppurs_pkg::result_t   result,
    output ppurs_pkg::pal_cmd_t  pal_cmd
);
    import ppurs_pkg::*;

    localparam logic [2:0] REG_CTRL   = 3'd0;
    localparam logic [2:0] REG_MASK   = 3'd1;
    localparam logic [2:0] REG_STATUS = 3'd2;
    localparam logic [2:0] REG_SCROLL = 3'd5;
    localparam logic [2:0] REG_ADDR   = 3'd6;
    localparam logic [2:0] REG_DATA   = 3'd7;

    localparam logic [1:0] FLAG_NONE = 2'd3;
    localparam logic [5:0] PAL_PAGE  = 6'h3F;
    localparam logic [4:0] LAST_ROW  = 5'd29;
    localparam logic [4:0] WRAP_ROW  = 5'd31;

    logic [7:0]  ctrl_reg,   ctrl_next;
    logic [7:0]  mask_reg,   mask_next;
    logic [2:0]  status_reg, status_next;
    logic [14:0] cur_reg,    cur_next;
    logic [14:0] temp_reg,   temp_next;
    logic [2:0]  finex_reg,  finex_next;
    logic        toggle_reg, toggle_next;
    logic [7:0]  buffer_reg, buffer_next;
    logic [7:0]  latch_reg,  latch_next;

    logic [13:0] data_addr;
    logic [13:0] stepped_addr;
    logic        in_palette;
    logic        rendering;
    logic [4:0]  coarse_y;
    logic [PAL_IDX_W-1:0] pal_index;

    always_comb begin
        data_addr    = cur_reg[13:0];
        stepped_addr = data_addr + (ctrl_reg[2] ? 14'd32 : 14'd1);
        in_palette   = (data_addr[13:8] == PAL_PAGE);
        rendering    = mask_reg[3] || mask_reg[4];
        coarse_y     = cur_reg[9:5];
        pal_index    = (data_addr[1:0] != 2'b00) ? data_addr[PAL_IDX_W-1:0]
                                                 : {1'b0, data_addr[3:2], 2'b00};
    end

    always_comb begin
        ctrl_next   = ctrl_reg;
        mask_next   = mask_reg;
        status_next = status_reg;
        cur_next    = cur_reg;
        temp_next   = temp_reg;
        finex_next  = finex_reg;
        toggle_next = toggle_reg;
        buffer_next = buffer_reg;
        latch_next  = latch_reg;

        result                = '0;
        result.mem_request    = REQ_NONE;
        pal_cmd               = '0;
        pal_cmd.index         = pal_index;
        pal_cmd.wdata         = bus_data[5:0];

        unique case (operation)
            OP_REG_WRITE: begin
                latch_next = bus_data;
                case (reg_index)
                    REG_CTRL: begin
                        ctrl_next = bus_data;
                        result.nmi_pulse = !ctrl_reg[7] && bus_data[7] && status_reg[0];
                        temp_next[11:10] = bus_data[1:0];
                    end
                    REG_MASK: begin
                        mask_next = bus_data;
                    end
                    REG_SCROLL: begin
                        if (!toggle_reg) begin
                            temp_next[4:0] = bus_data[7:3];
                            finex_next     = bus_data[2:0];
                        end else begin
                            temp_next[9:5]   = bus_data[7:3];
                            temp_next[14:12] = bus_data[2:0];
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_ADDR: begin
                        if (!toggle_reg) begin
                            temp_next[13:8] = bus_data[5:0];
                            temp_next[14]   = 1'b0;
                        end else begin
                            temp_next[7:0] = bus_data;
                            cur_next       = {temp_reg[14:8], bus_data};
                        end
                        toggle_next = !toggle_reg;
                    end
                    REG_DATA: begin
                        result.mem_request    = REQ_WRITE;
                        result.mem_address    = data_addr;
                        result.mem_write_data = bus_data;
                        pal_cmd.wr_en         = accept && in_palette;
                        cur_next              = {cur_reg[14], stepped_addr};
                    end
                    default: begin
                    end
                endcase
            end
            OP_REG_READ: begin
                case (reg_index)
                    REG_STATUS: begin
                        result.read_data = {status_reg[0], status_reg[1], status_reg[2],
                                            latch_reg[4:0]};
                        status_next[0] = 1'b0;
                        toggle_next    = 1'b0;
                        latch_next     = {status_reg[0], status_reg[1], status_reg[2],
                                          latch_reg[4:0]};
                    end
                    REG_DATA: begin
                        result.mem_request = REQ_READ;
                        if (!in_palette) begin
                            result.read_data   = buffer_reg;
                            latch_next         = buffer_reg;
                            result.mem_address = data_addr;
                        end else begin
                            result.pal_read    = 1'b1;
                            pal_cmd.rd_en      = accept;
                            result.mem_address = data_addr - 14'h1000;
                        end
                        cur_next = {cur_reg[14], stepped_addr};
                    end
                    default: begin
                        result.read_data = latch_reg;
                    end
                endcase
            end
            OP_MEM_RETURN: begin
                buffer_next = mem_data;
            end
            OP_SET_FLAG: begin
                if (flag_select != FLAG_NONE) begin
                    status_next[flag_select] = flag_value;
                end
            end
            OP_LINE_START: begin
                if (rendering) begin
                    cur_next[10]  = temp_reg[10];
                    cur_next[4:0] = temp_reg[4:0];
                end
            end
            OP_LINE_END: begin
                if (rendering) begin
                    if (cur_reg[14:12] != 3'd7) begin
                        cur_next[14:12] = cur_reg[14:12] + 3'd1;
                    end else begin
                        cur_next[14:12] = 3'd0;
                        if (coarse_y == LAST_ROW) begin
                            cur_next[9:5] = 5'd0;
                            cur_next[11]  = !cur_reg[11];
                        end else if (coarse_y == WRAP_ROW) begin
                            cur_next[9:5] = 5'd0;
                        end else begin
                            cur_next[9:5] = coarse_y + 5'd1;
                        end
                    end
                end
            end
            OP_RELOAD: begin
                if (rendering) begin
                    cur_next = temp_reg;
                end
            end
            OP_SOFT_RESET, OP_HARD_RESET: begin
                ctrl_next   = '0;
                mask_next   = '0;
                cur_next    = '0;
                temp_next   = '0;
                finex_next  = '0;
                toggle_next = 1'b0;
                buffer_next = '0;
                latch_next  = '0;
                if (operation == OP_HARD_RESET) begin
                    status_next   = '0;
                    pal_cmd.clear = accept;
                end
            end
            default: begin
            end
        endcase

        result.nmi_enable     = ctrl_next[7];
        result.render_on      = mask_next[3] || mask_next[4];
        result.scroll_address = cur_next;
        result.fine_x         = finex_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg   <= '0;
            mask_reg   <= '0;
            status_reg <= '0;
            cur_reg    <= '0;
            temp_reg   <= '0;
            finex_reg  <= '0;
            toggle_reg <= 1'b0;
            buffer_reg <= '0;
            latch_reg  <= '0;
        end else if (accept) begin
            ctrl_reg   <= ctrl_next;
            mask_reg   <= mask_next;
            status_reg <= status_next;
            cur_reg    <= cur_next;
            temp_reg   <= temp_next;
            finex_reg  <= finex_next;
            toggle_reg <= toggle_next;
            buffer_reg <= buffer_next;
            latch_reg  <= latch_next;
        end
    end

endmodule
